// ===== rtl/core/sibct_pkg.sv =====
// shared types, constants and helpers for the source ip byte counter table
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sibct_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  LIVE_WINDOW_RESET = 8'd3;

	// beat widths
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 104;
	localparam int M_TUSER_W = 3;

	// item kinds
	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// result outcomes
	localparam logic [2:0] OUT_UPDATED  = 3'd0;
	localparam logic [2:0] OUT_INSERTED = 3'd1;
	localparam logic [2:0] OUT_FULL     = 3'd2;
	localparam logic [2:0] OUT_NOT_IPV4 = 3'd3;
	localparam logic [2:0] OUT_READ     = 3'd4;

	typedef logic [IDX_W-1:0] idx_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic execute;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_result;
		logic out_free;
	} sts_t;

	// low four bits of an entry number
	function automatic logic [3:0] to_slot(input idx_t idx);
		logic [IDX_W+3:0] ext;
		begin
			ext = {4'b0000, idx};
			return ext[3:0];
		end
	endfunction

	// entry number from a four-bit read index
	function automatic idx_t from_read_index(input logic [3:0] ridx);
		logic [IDX_W+3:0] ext;
		begin
			ext = {{IDX_W{1'b0}}, ridx};
			return ext[IDX_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/core/sibct_ctrl.sv =====
// sequencing state machine: capture, lookup, execute, emit
// depends on sibct_pkg
`timescale 1ns / 1ps

module sibct_ctrl
	import sibct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.lookup = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				state_d = sts.has_result ? ST_RESP : ST_IDLE;
			end
			ST_RESP: begin
				// wait for room in the output register
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/sibct_datapath.sv =====
// entry table, address match, byte accumulation, seconds counter and output register
// depends on sibct_pkg; driven by sibct_ctrl
`timescale 1ns / 1ps

module sibct_datapath
	import sibct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 cfg_valid,
	input  logic [7:0]           cfg_data,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser
);

	// captured item
	logic [1:0]  op_q;
	logic [15:0] etype_q;
	logic [31:0] addr_q;
	logic [15:0] len_q;
	logic [3:0]  ridx_q;

	// table
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0] ent_addr_q [TABLE_ENTRIES];
	logic [31:0] ent_bytes_q [TABLE_ENTRIES];
	logic [31:0] ent_seen_q [TABLE_ENTRIES];

	logic [31:0] now_q;
	logic        full_q;
	logic [7:0]  window_q;

	// lookup results
	logic hit_q;
	idx_t hit_idx_q;
	logic free_q;
	idx_t free_idx_q;
	logic hit_d;
	idx_t hit_idx_d;
	logic free_d;
	idx_t free_idx_d;

	// chosen entry for the response
	logic       sel_ok_q;
	idx_t       sel_idx_q;
	logic [3:0] slot_q;
	logic [2:0] outcome_q;

	// output register
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	logic [32:0] sum;
	logic [31:0] sat_bytes;
	logic        r_valid;
	logic [31:0] r_addr;
	logic [31:0] r_bytes;
	logic [31:0] r_seen;
	logic [31:0] r_age;
	logic        r_live;

	assign sts.has_result = (op_q == OP_PACKET) || (op_q == OP_READ);
	assign sts.out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// parallel match and first free entry
	always_comb begin
		hit_d = 1'b0;
		hit_idx_d = '0;
		free_d = 1'b0;
		free_idx_d = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && ent_addr_q[i] == addr_q) begin
				hit_d = 1'b1;
				hit_idx_d = idx_t'(i);
			end
			if (!valid_q[i]) begin
				free_d = 1'b1;
				free_idx_d = idx_t'(i);
			end
		end
	end

	assign sum = {1'b0, ent_bytes_q[hit_idx_q]} + {17'd0, len_q};
	assign sat_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

	// response read of the selected entry
	always_comb begin
		r_valid = sel_ok_q && valid_q[sel_idx_q];
		r_addr  = r_valid ? ent_addr_q[sel_idx_q] : 32'd0;
		r_bytes = r_valid ? ent_bytes_q[sel_idx_q] : 32'd0;
		r_seen  = r_valid ? ent_seen_q[sel_idx_q] : 32'd0;
		r_age   = now_q - ent_seen_q[sel_idx_q];
		r_live  = r_valid && (r_age < {24'd0, window_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= s_tuser;
			etype_q <= s_tdata[15:0];
			addr_q  <= s_tdata[47:16];
			len_q   <= s_tdata[63:48];
			ridx_q  <= s_tdata[67:64];
		end
		if (cmd.lookup) begin
			hit_q      <= hit_d;
			hit_idx_q  <= hit_idx_d;
			free_q     <= free_d;
			free_idx_q <= free_idx_d;
		end
		if (cmd.execute) begin
			sel_ok_q  <= 1'b0;
			sel_idx_q <= '0;
			slot_q    <= 4'd0;
			outcome_q <= OUT_NOT_IPV4;
			case (op_q)
				OP_PACKET: begin
					if (etype_q != ETHERTYPE_IPV4) begin
						outcome_q <= OUT_NOT_IPV4;
					end else if (hit_q) begin
						ent_bytes_q[hit_idx_q] <= sat_bytes;
						ent_seen_q[hit_idx_q]  <= now_q;
						outcome_q <= OUT_UPDATED;
						sel_ok_q  <= 1'b1;
						sel_idx_q <= hit_idx_q;
						slot_q    <= to_slot(hit_idx_q);
					end else if (free_q) begin
						ent_addr_q[free_idx_q]  <= addr_q;
						ent_bytes_q[free_idx_q] <= {16'd0, len_q};
						ent_seen_q[free_idx_q]  <= now_q;
						outcome_q <= OUT_INSERTED;
						sel_ok_q  <= 1'b1;
						sel_idx_q <= free_idx_q;
						slot_q    <= to_slot(free_idx_q);
					end else begin
						outcome_q <= OUT_FULL;
					end
				end
				OP_READ: begin
					outcome_q <= OUT_READ;
					slot_q    <= ridx_q;
					sel_ok_q  <= (int'(ridx_q) < TABLE_ENTRIES);
					sel_idx_q <= from_read_index(ridx_q);
				end
				default: begin
				end
			endcase
		end
		if (cmd.emit) begin
			m_tuser_q <= outcome_q;
			m_tdata_q <= {1'b0, full_q, r_live, r_seen, r_bytes, r_addr, r_valid, slot_q};
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			now_q      <= 32'd0;
			full_q     <= 1'b0;
			window_q   <= LIVE_WINDOW_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
			if (cmd.execute) begin
				if (op_q == OP_TICK) begin
					now_q <= now_q + 32'd1;
				end
				if (op_q == OP_PACKET && etype_q == ETHERTYPE_IPV4 && !hit_q) begin
					if (free_q) begin
						valid_q[free_idx_q] <= 1'b1;
						full_q <= 1'b0;
					end else begin
						full_q <= 1'b1;
					end
				end
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/source_ip_byte_counter_table.sv =====
// top level of the per-source ipv4 byte counter table
// depends on sibct_pkg, sibct_ctrl and sibct_datapath
`timescale 1ns / 1ps

// Keeps a byte total and last-seen second for up to 16 source addresses.
// Each input beat is a packet, a one-second tick or a read of one entry;
// packets and reads give one result beat, ticks give none. The block works
// on one item at a time. A packet or a read passes through capture, parallel
// address match, table update and response, and the response may wait for
// the output register to drain; a tick has no response and skips that step.
// The output register lets the next item be accepted while a result is still
// waiting. The table is empty after reset with no clearing pass; the live
// window register may be written only while the block is idle.

module source_ip_byte_counter_table
	import sibct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// ether_type[15:0], source_ip[47:16], frame_length[63:48], read_index[67:64], zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// op[1:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// slot[3:0], slot_valid[4], slot_address[36:5], slot_bytes[68:37],
	// slot_last_seen[100:69], slot_live[101], full_flag[102], zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	// outcome[2:0]
	output logic [M_TUSER_W-1:0] m_tuser
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	sibct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sibct_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== rtl/core/sibct_checker.sv =====
// port-level checks for source_ip_byte_counter_table and the bind that attaches them
// depends on sibct_pkg
`timescale 1ns / 1ps

module sibct_checker
	import sibct_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

	// one item in flight: no accept right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// an empty entry reports nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[101:5] == '0)
		else $error("invalid entry carries data");

	// refused or non-ipv4 packets touch no entry
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == OUT_FULL || m_tuser == OUT_NOT_IPV4) |-> m_tdata[101:0] == '0)
		else $error("untouched outcome carries an entry");

	// refusal and full flag agree
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == OUT_FULL |-> m_tdata[102])
		else $error("table full outcome without full flag");

endmodule

bind source_ip_byte_counter_table sibct_checker u_sibct_checker (.*);
